// ===== rtl/core/waveform_minmax_peak_decimator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the waveform min/max peak decimator
// Shared checker shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_MINMAX_PEAK_DECIMATOR_MACROS_SVH
`define WAVEFORM_MINMAX_PEAK_DECIMATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define WMPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WMPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpd_pkg
// Types and fixed widths shared by the peak decimator modules.
// ----------------------------------------------------------------------------
package wmpd_pkg;

  // Fixed field widths
  localparam int FRAME_W   = 24;  // frame indices and window registers
  localparam int SAMPLE_W  = 24;  // Q1.23 samples
  localparam int NUM_W     = 7;   // bucket number on the output
  localparam int MAX_W     = 23;  // bucket maximum on the output
  localparam int CHAN_W    = 2;   // channels register
  localparam int CFG_IDX_W = 2;   // register index
  localparam int LANES     = 2;   // sample lanes carried by one item

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANS = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/wmpd_lane.sv =====
// ----------------------------------------------------------------------------
// wmpd_lane
// One sample lane: saturates a sample to the working range and gates it.
// ----------------------------------------------------------------------------
module wmpd_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  wmpd_pkg::sample_t sample,
  input  logic              active,
  output wmpd_pkg::sample_t lane_val
);

  // Saturation limits; no clamping when the range covers the full field
  localparam int SAT_HI_I = (SAMPLE_BITS >= wmpd_pkg::SAMPLE_W) ?
                            ((1 << (wmpd_pkg::SAMPLE_W - 1)) - 1) :
                            ((1 << (SAMPLE_BITS - 1)) - 1);
  localparam int SAT_LO_I = -SAT_HI_I - 1;
  localparam wmpd_pkg::sample_t SAT_HI = wmpd_pkg::SAMPLE_W'(SAT_HI_I);
  localparam wmpd_pkg::sample_t SAT_LO = wmpd_pkg::SAMPLE_W'(SAT_LO_I);

  wmpd_pkg::sample_t sat;

  // Clamp, then show zero for an unused lane (neutral for min and max)
  always_comb begin
    if (sample > SAT_HI) begin
      sat = SAT_HI;
    end else if (sample < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sample;
    end
    lane_val = active ? sat : '0;
  end

endmodule

// ===== rtl/core/wmpd_merge.sv =====
// ----------------------------------------------------------------------------
// wmpd_merge
// Folds the lane values into the running bucket minimum and maximum.
// ----------------------------------------------------------------------------
module wmpd_merge (
  input  wmpd_pkg::sample_t run_min,
  input  wmpd_pkg::sample_t run_max,
  input  wmpd_pkg::sample_t lane_val [wmpd_pkg::LANES],
  output wmpd_pkg::sample_t new_min,
  output wmpd_pkg::sample_t new_max
);

  // Lanes are independent; a short compare chain over them
  always_comb begin
    new_min = run_min;
    new_max = run_max;
    for (int i = 0; i < wmpd_pkg::LANES; i++) begin
      if (lane_val[i] < new_min) begin
        new_min = lane_val[i];
      end
      if (lane_val[i] > new_max) begin
        new_max = lane_val[i];
      end
    end
  end

endmodule

// ===== rtl/core/wmpd_div.sv =====
// ----------------------------------------------------------------------------
// wmpd_div
// Restoring divider, one quotient bit per cycle, for bucket boundaries.
// ----------------------------------------------------------------------------
`include "waveform_minmax_peak_decimator_macros.svh"

module wmpd_div #(
  parameter int BW = 8,   // divisor width
  parameter int DW = 32   // dividend width
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DW-1:0]                dividend,
  input  logic [BW-1:0]                divisor,
  output wmpd_pkg::div_stat_t          stat,
  output logic [wmpd_pkg::FRAME_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r;
  logic [BW-1:0]    rem_r;
  logic [BW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [BW:0]      trial;
  logic             take;
  logic [BW:0]      diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[DW-1]};
  assign take  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  // Iteration registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], take};
      rem_r <= take ? diff[BW-1:0] : trial[BW-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CNT_W'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  // Quotient never exceeds the window length
  assign quotient  = quo_r[wmpd_pkg::FRAME_W-1:0];

  `WMPD_ASSERT_NEXT(a_start_busy, start, busy_r, "divider did not start")
  `WMPD_ASSERT_SAME(a_done_on_fall, $fell(busy_r), done_r, "divider stopped without done")
  `WMPD_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held past one cycle")

endmodule

// ===== rtl/core/waveform_minmax_peak_decimator.sv =====
// ----------------------------------------------------------------------------
// waveform_minmax_peak_decimator
// Min/max peak decimator for a waveform overview: one result item per bucket.
// ----------------------------------------------------------------------------
// One frame item is handled at a time. For an item that falls in an active
// bucket the boundary is recomputed per item by a bit-serial divider over a
// DW-bit dividend, DW = 24 + clog2(MAX_BUCKETS + 1), one quotient bit a cycle,
// and that divider sets the item time. Items for an empty buffer leave after the
// window step and items past the last bucket after the span step. A finished
// result waits in the output register while the next item is already being taken;
// an item that closes a bucket while that register is still full waits until it is read.
// ----------------------------------------------------------------------------
`include "waveform_minmax_peak_decimator_macros.svh"

module waveform_minmax_peak_decimator #(
  parameter int MAX_BUCKETS = 128,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Frame items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_first_frame,
  input  wmpd_pkg::sample_t              in_sample_ch0,
  input  wmpd_pkg::sample_t              in_sample_ch1,
  // Bucket result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wmpd_pkg::NUM_W-1:0]     out_bucket_number,
  output wmpd_pkg::sample_t              out_bucket_min,
  output logic [wmpd_pkg::MAX_W-1:0]     out_bucket_max,
  output logic                           out_last_bucket,
  // Register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wmpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmpd_pkg::FRAME_W-1:0]   cfg_data
);

  localparam int FW = wmpd_pkg::FRAME_W;
  localparam int BW = $clog2(MAX_BUCKETS + 1);
  localparam int DW = FW + BW;
  localparam logic [FW-1:0] FRAME_TOP = {FW{1'b1}};
  localparam logic [FW-1:0] MAX_B_FW  = FW'(MAX_BUCKETS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WIN  = 6'b000010,
    ST_SPAN = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Registers
  logic [FW-1:0]                 total_r;
  logic [FW-1:0]                 start_cfg_r;
  logic [FW-1:0]                 end_cfg_r;
  logic [wmpd_pkg::CHAN_W-1:0]   chans_cfg_r;

  // Per-buffer state
  logic [FW-1:0]                 fc_r;
  logic [BW-1:0]                 cb_r;
  wmpd_pkg::sample_t             run_min_r;
  wmpd_pkg::sample_t             run_max_r;

  // Item being worked on and its window
  logic [FW-1:0]                 idx_r;
  wmpd_pkg::sample_t             smp_r [wmpd_pkg::LANES];
  logic [FW-1:0]                 win_start_r;
  logic [FW-1:0]                 win_end_r;
  logic [FW-1:0]                 usable_r;
  logic [BW-1:0]                 buckets_r;

  // Output register
  logic                          out_valid_r;
  logic [wmpd_pkg::NUM_W-1:0]    num_r;
  wmpd_pkg::sample_t             min_r;
  logic [wmpd_pkg::MAX_W-1:0]    max_r;
  logic                          last_r;

  logic                          accept;
  logic [FW-1:0]                 idx_nxt;
  logic [FW-1:0]                 tot_m1;
  logic [FW-1:0]                 win_start_nxt;
  logic [FW-1:0]                 end_a;
  logic [FW-1:0]                 start_p1;
  logic [FW-1:0]                 end_b;
  logic [FW-1:0]                 win_end_nxt;
  logic [FW-1:0]                 usable_nxt;
  logic [BW-1:0]                 buckets_nxt;
  logic [BW-1:0]                 cb_p1;
  logic [DW-1:0]                 dividend;
  logic [FW-1:0]                 quotient;
  wmpd_pkg::div_stat_t           div_stat;
  logic [FW:0]                   bnd;
  logic [FW:0]                   idx_p1;
  logic                          in_win;
  logic                          close;
  logic                          stall;
  logic                          two_ch;
  logic [wmpd_pkg::LANES-1:0]    lane_active;
  wmpd_pkg::sample_t             lane_val [wmpd_pkg::LANES];
  wmpd_pkg::sample_t             new_min;
  wmpd_pkg::sample_t             new_max;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      start_cfg_r <= '0;
      end_cfg_r   <= '0;
      chans_cfg_r <= wmpd_pkg::CHAN_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        wmpd_pkg::CFG_TOTAL: total_r     <= cfg_data;
        wmpd_pkg::CFG_START: start_cfg_r <= cfg_data;
        wmpd_pkg::CFG_END:   end_cfg_r   <= cfg_data;
        wmpd_pkg::CFG_CHANS: chans_cfg_r <= cfg_data[wmpd_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame index of the incoming item
  assign idx_nxt = in_first_frame ? '0 : fc_r;

  // Window clamp: start below total, end in (start, total]
  always_comb begin
    tot_m1        = total_r - 1'b1;
    win_start_nxt = (start_cfg_r > tot_m1) ? tot_m1 : start_cfg_r;
    end_a         = (end_cfg_r > start_cfg_r) ? end_cfg_r : total_r;
    start_p1      = win_start_nxt + 1'b1;
    end_b         = (end_a < start_p1) ? start_p1 : end_a;
    win_end_nxt   = (end_b > total_r) ? total_r : end_b;
  end

  // Bucket count
  assign usable_nxt  = win_end_r - win_start_r;
  assign buckets_nxt = (usable_nxt < MAX_B_FW) ? usable_nxt[BW-1:0] : BW'(MAX_BUCKETS);

  // Boundary numerator (cb + 1) * usable, registered inside the divider
  assign cb_p1    = cb_r + 1'b1;
  assign dividend = DW'(cb_p1) * DW'(usable_r);

  wmpd_div #(
    .BW (BW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_MUL),
    .dividend (dividend),
    .divisor  (buckets_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Channel lanes: zero and one mean one channel, two and three mean two
  assign two_ch      = chans_cfg_r[1] && (CHANNELS >= 2);
  assign lane_active = {two_ch, 1'b1};

  for (genvar gi = 0; gi < wmpd_pkg::LANES; gi++) begin : g_lane
    wmpd_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .sample   (smp_r[gi]),
      .active   (lane_active[gi]),
      .lane_val (lane_val[gi])
    );
  end

  wmpd_merge u_merge (
    .run_min  (run_min_r),
    .run_max  (run_max_r),
    .lane_val (lane_val),
    .new_min  (new_min),
    .new_max  (new_max)
  );

  // Bucket close decision
  assign bnd    = {1'b0, win_start_r} + {1'b0, quotient};
  assign idx_p1 = {1'b0, idx_r} + 1'b1;
  assign in_win = (idx_r >= win_start_r) && (idx_r < win_end_r);
  assign close  = in_win && (idx_p1 >= bnd);
  assign stall  = close && out_valid_r && !out_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = ST_WIN;
      end
      ST_WIN:  state_nxt = (total_r == '0) ? ST_IDLE : ST_SPAN;
      ST_SPAN: state_nxt = (cb_r >= buckets_nxt) ? ST_IDLE : ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) begin
        state_nxt = ST_FIN;
      end
      ST_FIN:  if (!stall) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item and window payload
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= idx_nxt;
      smp_r[0] <= in_sample_ch0;
      smp_r[1] <= in_sample_ch1;
    end
    if (state_r == ST_WIN) begin
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
    end
    if (state_r == ST_SPAN) begin
      usable_r  <= usable_nxt;
      buckets_r <= buckets_nxt;
    end
  end

  // Frame counter, bucket and running extremes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r      <= '0;
      cb_r      <= '0;
      run_min_r <= '0;
      run_max_r <= '0;
    end else if (accept) begin
      fc_r <= (idx_nxt == FRAME_TOP) ? FRAME_TOP : idx_nxt + 1'b1;
      if (in_first_frame) begin
        cb_r      <= '0;
        run_min_r <= '0;
        run_max_r <= '0;
      end
    end else if (state_r == ST_FIN && !stall) begin
      if (close) begin
        cb_r      <= cb_p1;
        run_min_r <= '0;
        run_max_r <= '0;
      end else if (in_win) begin
        run_min_r <= new_min;
        run_max_r <= new_max;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && close && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && close && !stall) begin
      num_r  <= wmpd_pkg::NUM_W'(cb_r);
      min_r  <= new_min;
      max_r  <= new_max[wmpd_pkg::MAX_W-1:0];
      last_r <= (cb_p1 == buckets_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bucket_number = num_r;
  assign out_bucket_min    = min_r;
  assign out_bucket_max    = max_r;
  assign out_last_bucket   = last_r;

  `WMPD_ASSERT_SAME(a_fin_bucket, state_r == ST_FIN, cb_r < buckets_r, "bucket past count")
  `WMPD_ASSERT_SAME(a_min_nonpos, out_valid, out_bucket_min <= 0, "bucket minimum above zero")
  `WMPD_ASSERT_NEXT(a_accept_win, accept, state_r == ST_WIN, "accepted item not windowed")
  `WMPD_ASSERT_NEXT(a_div_fin, state_r == ST_DIV && div_stat.done, state_r == ST_FIN, "quotient lost")
  `WMPD_ASSERT_SAME(a_div_idle, state_r != ST_DIV, !div_stat.busy, "divider busy out of turn")

endmodule
